// ===== rtl/rcrv_pkg.sv =====
// ============================================================================
// rcrv_pkg
// Shared types, constants and row decode helpers for the repeat-vote decoder.
// ============================================================================
package rcrv_pkg;

   localparam int MAX_ROWS     = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = $clog2(MAX_ROWS);
   localparam int CNT_W        = $clog2(MAX_ROWS + 1);
   localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);

   localparam int ROW_BITS_W = 10;
   localparam int BYTE_W     = 8;
   localparam int CODE_W     = 12;
   localparam int VOTE_W     = 5;
   localparam int CMP_W      = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;

   localparam logic [ROW_BITS_W-1:0] ROW_LEN    = 10'd13;
   localparam logic [BYTE_W-1:0]     START_MASK = 8'h80;
   localparam logic [BYTE_W-1:0]     TOP_MASK   = 8'h7f;
   localparam logic [CODE_W-1:0]     CODE_NONE  = 12'h000;
   localparam logic [CODE_W-1:0]     CODE_FULL  = 12'hfff;
   localparam logic [VOTE_W-1:0]     VOTE_MAX   = '1;

   localparam logic [VOTE_W-1:0] MIN_REPEATS_RESET = 5'd3;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MIN_REPEATS = 1'b0;   // register index (paddr[2])

   localparam logic STATUS_CODE = 1'b0;
   localparam logic STATUS_NONE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LD_I,
      ST_RD_J,
      ST_CMP_J,
      ST_DECIDE,
      ST_PUSH,
      ST_FINAL
   } vote_state_type;

   function automatic logic [CODE_W-1:0] row_code(input logic [BYTE_W-1:0] b0,
                                                  input logic [BYTE_W-1:0] b1);
      logic [BYTE_W-1:0] top;
      top = b0 & TOP_MASK;
      return {top[6:0], b1[7:3]};
   endfunction

   function automatic logic row_keep(input logic [ROW_BITS_W-1:0] bits,
                                     input logic [BYTE_W-1:0]     b0,
                                     input logic [BYTE_W-1:0]     b1);
      logic [CODE_W-1:0] c;
      c = row_code(b0, b1);
      return (bits == ROW_LEN) && ((b0 & START_MASK) != '0) &&
             (c != CODE_NONE) && (c != CODE_FULL);
   endfunction

   function automatic logic [VOTE_W-1:0] sat_votes(input logic [CNT_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      return (w > CMP_W'(VOTE_MAX)) ? VOTE_MAX : VOTE_W'(w);
   endfunction

endpackage

// ===== rtl/rcrv_ram.sv =====
// ============================================================================
// rcrv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rcrv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rcrv_csr.sv =====
// ============================================================================
// rcrv_csr
// APB-style register port holding the vote threshold.
// ============================================================================
module rcrv_csr
   import rcrv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [VOTE_W-1:0]     min_repeats
);

   logic [VOTE_W-1:0] min_repeats_ff;
   logic [VOTE_W-1:0] min_repeats_in;
   logic              hit;

   assign hit = (csr_paddr[2] == REG_MIN_REPEATS);

   always_comb begin
      min_repeats_in = min_repeats_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         min_repeats_in = csr_pwdata[VOTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_repeats_ff <= MIN_REPEATS_RESET;
      end else begin
         min_repeats_ff <= min_repeats_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = hit ? 32'(min_repeats_ff) : 32'd0;
   assign min_repeats = min_repeats_ff;

endmodule

// ===== rtl/rcrv_vote.sv =====
// ============================================================================
// rcrv_vote
// Code store, vote sequencer with one shared compare/count unit, result reg.
// ============================================================================
module rcrv_vote
   import rcrv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VOTE_W-1:0]     min_repeats,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ROW_BITS_W-1:0] row_bits,
   input  logic [BYTE_W-1:0]     first_byte,
   input  logic [BYTE_W-1:0]     second_byte,
   input  logic                  last_row,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CODE_W-1:0]     code,
   output logic [VOTE_W-1:0]     vote_count,
   output logic                  status,
   output logic                  last_result
);

   vote_state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  votes_ff, votes_in;
   logic              seen_ff, seen_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic [CODE_W-1:0] cur_ff, cur_in;
   logic              pend_ff, pend_in;
   logic [CODE_W-1:0] pend_code_ff, pend_code_in;
   logic [CNT_W-1:0]  pend_votes_ff, pend_votes_in;

   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic [VOTE_W-1:0] out_votes_ff, out_votes_in;
   logic              out_status_ff, out_status_in;
   logic              out_last_ff, out_last_in;

   logic              accept;
   logic              keep;
   logic              wr_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [CODE_W-1:0] rd_data;
   logic              slot_free;
   logic              more;
   logic              j_last;
   logic              qualify;

   assign accept    = in_valid && (state_ff == ST_IDLE);
   assign keep      = row_keep(row_bits, first_byte, second_byte);
   assign wr_en     = accept && keep && (count_ff < CNT_W'(MAX_ROWS));
   assign slot_free = !out_valid_ff || out_ready;
   assign more      = (i_ff < count_ff) && (nres_ff < NRES_W'(RESULT_LIMIT));
   assign j_last    = (j_ff + CNT_W'(1)) == count_ff;
   assign qualify   = (CMP_W'(votes_ff) >= CMP_W'(min_repeats)) && !seen_ff;
   assign rd_addr   = (state_ff == ST_RD_I) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   rcrv_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (row_code(first_byte, second_byte)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && last_row) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I:   state_in = more ? ST_LD_I : ST_FINAL;
         ST_LD_I:   state_in = ST_RD_J;
         ST_RD_J:   state_in = ST_CMP_J;
         ST_CMP_J:  state_in = j_last ? ST_DECIDE : ST_RD_J;
         ST_DECIDE: state_in = (qualify && pend_ff) ? ST_PUSH : ST_RD_I;
         ST_PUSH: begin
            if (slot_free) begin
               state_in = ST_RD_I;
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      votes_in      = votes_ff;
      seen_in       = seen_ff;
      nres_in       = nres_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      pend_code_in  = pend_code_ff;
      pend_votes_in = pend_votes_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_code_in   = out_code_ff;
      out_votes_in  = out_votes_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            i_in    = '0;
            nres_in = '0;
            pend_in = 1'b0;
         end
         ST_LD_I: begin
            cur_in   = rd_data;
            j_in     = '0;
            votes_in = '0;
            seen_in  = 1'b0;
         end
         ST_CMP_J: begin
            if (rd_data == cur_ff) begin
               votes_in = votes_ff + CNT_W'(1);
               if (j_ff < i_ff) begin
                  seen_in = 1'b1;
               end
            end
            j_in = j_ff + CNT_W'(1);
         end
         ST_DECIDE: begin
            if (qualify) begin
               nres_in = nres_ff + NRES_W'(1);
               if (!pend_ff) begin
                  pend_in       = 1'b1;
                  pend_code_in  = cur_ff;
                  pend_votes_in = votes_ff;
                  i_in          = i_ff + CNT_W'(1);
               end
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_code_in   = pend_code_ff;
               out_votes_in  = sat_votes(pend_votes_ff);
               out_status_in = STATUS_CODE;
               out_last_in   = 1'b0;
               pend_code_in  = cur_ff;
               pend_votes_in = votes_ff;
               i_in          = i_ff + CNT_W'(1);
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               count_in     = '0;
               if (pend_ff) begin
                  out_code_in   = pend_code_ff;
                  out_votes_in  = sat_votes(pend_votes_ff);
                  out_status_in = STATUS_CODE;
               end else begin
                  out_code_in   = CODE_NONE;
                  out_votes_in  = '0;
                  out_status_in = STATUS_NONE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      votes_ff      <= votes_in;
      seen_ff       <= seen_in;
      nres_ff       <= nres_in;
      cur_ff        <= cur_in;
      pend_code_ff  <= pend_code_in;
      pend_votes_ff <= pend_votes_in;
      out_code_ff   <= out_code_in;
      out_votes_ff  <= out_votes_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign in_ready    = (state_ff == ST_IDLE);
   assign out_valid   = out_valid_ff;
   assign code        = out_code_ff;
   assign vote_count  = out_votes_ff;
   assign status      = out_status_ff;
   assign last_result = out_last_ff;

endmodule

// ===== rtl/remote_code_repeat_vote_top.sv =====
// ============================================================================
// remote_code_repeat_vote_top
// Repeat-voting decoder for 12-bit pulse-width remote codes.
// ============================================================================
// Each req item is one demodulated row. Rows that are not last yield nothing;
// a valid 13-bit row with its start bit set and a code other than all zeros or
// all ones is written to a 16-entry code store. The last row starts the vote:
// a sequencer walks the store with one compare/count unit, reading and comparing
// each stored entry against each candidate in turn; rsp back-pressure stalls it.
// req_tready is low during the vote. Results come out in order of first
// appearance; if none reaches min_repeats, one no-code item with status set is
// sent. rsp_tlast marks the final item of a transmission.
module remote_code_repeat_vote_top
   import rcrv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // row_bits[9:0], first_byte[17:10],
                                              // second_byte[25:18], zero pad
   input  logic                  req_tlast,   // last_row
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // code[11:0], vote_count[16:12], zero pad
   output logic                  rsp_tuser,   // status
   output logic                  rsp_tlast,   // last_result
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [VOTE_W-1:0] min_repeats;
   logic [CODE_W-1:0] code;
   logic [VOTE_W-1:0] vote_count;

   rcrv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .min_repeats (min_repeats)
   );

   rcrv_vote u_vote (
      .clock       (clock),
      .reset       (reset),
      .min_repeats (min_repeats),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .row_bits    (req_tdata[9:0]),
      .first_byte  (req_tdata[17:10]),
      .second_byte (req_tdata[25:18]),
      .last_row    (req_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .code        (code),
      .vote_count  (vote_count),
      .status      (rsp_tuser),
      .last_result (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, vote_count, code};

endmodule
